/* hw/rtl/clcd_pkg.sv */
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and lookup functions of the four-bit character LCD
// write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_DATA  = 3'd1;
    localparam logic [2:0] ACT_INSTR = 3'd2;
    localparam logic [2:0] ACT_POS   = 3'd3;
    localparam logic [2:0] ACT_INIT  = 3'd4;
    localparam logic [2:0] ACT_CLEAR = 3'd5;

    localparam logic [1:0] CFG_DISPLAY_TYPE = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_CTRL = 2'd1;
    localparam logic [1:0] CFG_ENTRY_MODE   = 2'd2;

    localparam logic [2:0] DISPLAY_TYPE_RESET = 3'd2;
    localparam logic [2:0] DISPLAY_CTRL_RESET = 3'd4;
    localparam logic [1:0] ENTRY_MODE_RESET   = 2'd2;

    localparam logic [3:0]  STEP_INIT      = 4'd0;
    localparam logic [3:0]  STEP_CLEAR     = 4'd10;
    localparam logic [3:0]  STEP_LAST      = 4'd12;
    localparam logic [12:0] POST_BYTE_WAIT = 13'd50;

    typedef struct packed {
        logic [2:0] display_type;
        logic [2:0] display_control_flags;
        logic [1:0] entry_flags;
    } cfg_t;

    typedef struct packed {
        logic [3:0] lcd_data_nibble;
        logic       lcd_enable;
        logic       lcd_register_select;
        logic       busy_res;
        logic       accepted;
    } res_t;

    function automatic logic [2:0] geo_rows(input logic [2:0] t);
        case (t)
            3'd1:          geo_rows = 3'd1;
            3'd3, 3'd5:    geo_rows = 3'd4;
            default:       geo_rows = 3'd2;
        endcase
    endfunction

    function automatic logic [5:0] geo_cols(input logic [2:0] t);
        case (t)
            3'd0:       geo_cols = 6'd8;
            3'd4, 3'd5: geo_cols = 6'd20;
            3'd6:       geo_cols = 6'd40;
            default:    geo_cols = 6'd16;
        endcase
    endfunction

    function automatic logic [6:0] geo_base(input logic [2:0] t, input logic [1:0] r);
        logic [6:0] base;
        base = 7'h00;
        case (r)
            2'd1:    base = (t == 3'd1) ? 7'h00 : 7'h40;
            2'd2:    base = (t == 3'd3) ? 7'h10 : ((t == 3'd5) ? 7'h14 : 7'h00);
            2'd3:    base = (t == 3'd3) ? 7'h50 : ((t == 3'd5) ? 7'h54 : 7'h00);
            default: base = 7'h00;
        endcase
        geo_base = base;
    endfunction

    function automatic logic [12:0] step_wait(input logic [3:0] s);
        case (s)
            4'd1:    step_wait = 13'd4500;
            4'd3:    step_wait = 13'd150;
            4'd5:    step_wait = 13'd100;
            4'd11:   step_wait = 13'd1600;
            default: step_wait = 13'd0;
        endcase
    endfunction

    function automatic logic [7:0] step_byte(input logic [3:0] s, input cfg_t cfg);
        case (s)
            4'd0, 4'd2, 4'd4: step_byte = 8'h03;
            4'd6:    step_byte = 8'h02;
            4'd7:    step_byte = (geo_rows(cfg.display_type) == 3'd1) ? 8'h20 : 8'h28;
            4'd8:    step_byte = 8'h08 | {5'd0, cfg.display_control_flags};
            4'd9:    step_byte = 8'h04 | {6'd0, cfg.entry_flags};
            4'd10:   step_byte = 8'h01;
            default: step_byte = 8'h80;
        endcase
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/clcd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// clcd_cfg_regs
// Configuration registers: display geometry, display control flags and
// entry mode flags.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_cfg_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [2:0]    cfg_data,
    output clcd_pkg::cfg_t     cfg
);

    clcd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.display_type          <= clcd_pkg::DISPLAY_TYPE_RESET;
            cfg_reg.display_control_flags <= clcd_pkg::DISPLAY_CTRL_RESET;
            cfg_reg.entry_flags           <= clcd_pkg::ENTRY_MODE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                clcd_pkg::CFG_DISPLAY_TYPE: cfg_reg.display_type <= cfg_data;
                clcd_pkg::CFG_DISPLAY_CTRL: cfg_reg.display_control_flags <= cfg_data;
                clcd_pkg::CFG_ENTRY_MODE:   cfg_reg.entry_flags <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/clcd_seq_core.sv */
// ----------------------------------------------------------------------------
// clcd_seq_core
// Sequencer state and next-state logic. One enabled cycle advances the
// sequencer by one tick and presents the pin levels after that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_seq_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire logic [2:0]    action,
    input  wire logic [7:0]    data_byte,
    input  wire logic [2:0]    row,
    input  wire logic [5:0]    column,
    input  clcd_pkg::cfg_t     cfg,
    output clcd_pkg::res_t     res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HI1,
        PH_LO1,
        PH_HI2,
        PH_WAIT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  step_reg, step_next;
    logic [12:0] wait_reg, wait_next;
    logic [7:0]  byte_reg, byte_next;
    logic        rs_reg, rs_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic        enable_reg, enable_next;

    logic        request;
    logic        accepted;
    logic        start_req;
    logic [3:0]  start_s;
    logic [12:0] start_wait;
    logic        begin_req;
    logic [7:0]  begin_b;
    logic        begin_rs;
    logic [2:0]  rows_max;
    logic [5:0]  cols_max;
    logic [2:0]  row_c;
    logic [5:0]  col_c;
    logic [7:0]  pos_addr;

    assign request = action inside {[clcd_pkg::ACT_DATA:clcd_pkg::ACT_CLEAR]};

    always_comb begin
        rows_max = clcd_pkg::geo_rows(cfg.display_type);
        cols_max = clcd_pkg::geo_cols(cfg.display_type);
        row_c    = (row == 3'd0) ? 3'd1 : row;
        if (row_c > rows_max) begin
            row_c = rows_max;
        end
        col_c = (column == 6'd0) ? 6'd1 : column;
        if (col_c > cols_max) begin
            col_c = cols_max;
        end
        pos_addr = {1'b0, clcd_pkg::geo_base(cfg.display_type, 2'(row_c - 3'd1))}
                   + {2'b00, col_c} - 8'd1;
    end

    always_comb begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        wait_next   = wait_reg;
        byte_next   = byte_reg;
        rs_next     = rs_reg;
        nibble_next = nibble_reg;
        enable_next = enable_reg;
        accepted    = 1'b1;
        start_req   = 1'b0;
        start_s     = step_reg;
        start_wait  = 13'd0;
        begin_req   = 1'b0;
        begin_b     = 8'd0;
        begin_rs    = 1'b0;

        if (phase_reg != PH_IDLE) begin
            accepted = !request;
            case (phase_reg)
                PH_HI1: begin
                    nibble_next = byte_reg[3:0];
                    enable_next = 1'b0;
                    phase_next  = PH_LO1;
                end
                PH_LO1: begin
                    enable_next = 1'b1;
                    phase_next  = PH_HI2;
                end
                PH_HI2: begin
                    enable_next = 1'b0;
                    wait_next   = clcd_pkg::POST_BYTE_WAIT - 13'd1;
                    phase_next  = PH_WAIT;
                end
                PH_WAIT: begin
                    if (wait_reg != 13'd0) begin
                        wait_next = wait_reg - 13'd1;
                    end else if (step_reg >= clcd_pkg::STEP_LAST) begin
                        phase_next = PH_IDLE;
                    end else begin
                        start_req = 1'b1;
                        start_s   = step_reg + 4'd1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end else if (request) begin
            case (action)
                clcd_pkg::ACT_DATA: begin
                    step_next = clcd_pkg::STEP_LAST;
                    begin_req = 1'b1;
                    begin_b   = data_byte;
                    begin_rs  = 1'b1;
                end
                clcd_pkg::ACT_INSTR: begin
                    step_next = clcd_pkg::STEP_LAST;
                    begin_req = 1'b1;
                    begin_b   = data_byte;
                end
                clcd_pkg::ACT_POS: begin
                    step_next = clcd_pkg::STEP_LAST;
                    begin_req = 1'b1;
                    begin_b   = 8'h80 | pos_addr;
                end
                clcd_pkg::ACT_INIT: begin
                    start_req = 1'b1;
                    start_s   = clcd_pkg::STEP_INIT;
                end
                default: begin
                    start_req = 1'b1;
                    start_s   = clcd_pkg::STEP_CLEAR;
                end
            endcase
        end

        if (start_req) begin
            step_next  = start_s;
            start_wait = clcd_pkg::step_wait(start_s);
            if (start_wait != 13'd0) begin
                wait_next  = start_wait - 13'd1;
                phase_next = PH_WAIT;
            end else begin
                begin_req = 1'b1;
                begin_b   = clcd_pkg::step_byte(start_s, cfg);
                begin_rs  = 1'b0;
            end
        end

        if (begin_req) begin
            byte_next   = begin_b;
            rs_next     = begin_rs;
            nibble_next = begin_b[7:4];
            enable_next = 1'b1;
            phase_next  = PH_HI1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            step_reg   <= 4'd0;
            wait_reg   <= 13'd0;
            byte_reg   <= 8'd0;
            rs_reg     <= 1'b0;
            nibble_reg <= 4'd0;
            enable_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            wait_reg   <= wait_next;
            byte_reg   <= byte_next;
            rs_reg     <= rs_next;
            nibble_reg <= nibble_next;
            enable_reg <= enable_next;
        end
    end

    assign res.accepted            = accepted;
    assign res.busy_res            = (phase_next != PH_IDLE);
    assign res.lcd_register_select = rs_next;
    assign res.lcd_enable          = enable_next;
    assign res.lcd_data_nibble     = nibble_next;

endmodule

`default_nettype wire

/* hw/rtl/char_lcd_nibble_write_sequencer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Four-bit character LCD writer driven by one transfer per microsecond tick.
// ----------------------------------------------------------------------------
// Every input transfer is one tick of the LCD timing and yields exactly one
// result transfer with the RS, E and D7..D4 levels after that tick. Requests
// are taken only while the sequencer is idle; a request that arrives while it
// is busy comes back with accepted low and still counts as a tick. The block
// sustains one transfer per clock while results are taken: an input register
// feeds the sequencer logic, which loads a result register, and a stalled
// result only holds the pipeline while both registers are full. Configuration
// writes are taken in every cycle.
`default_nettype none

module char_lcd_nibble_write_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], data_byte[10:3], row[13:11], column[19:14], zero fill
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // accepted[0], busy_res[1], lcd_register_select[2], lcd_enable[3],
    // lcd_data_nibble[7:4]
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data
);

    logic           in_valid_reg;
    logic [19:0]    in_data_reg;
    logic           out_valid_reg;
    clcd_pkg::res_t out_data_reg;
    logic           step_en;
    clcd_pkg::cfg_t cfg;
    clcd_pkg::res_t res;

    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    clcd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clcd_seq_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .action    (in_data_reg[2:0]),
        .data_byte (in_data_reg[10:3]),
        .row       (in_data_reg[13:11]),
        .column    (in_data_reg[19:14]),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step_en) begin
                in_valid_reg <= 1'b0;
            end
            if (step_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[19:0];
        end
        if (step_en) begin
            out_data_reg <= res;
        end
    end

    a_enable_implies_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[1])
        else $error("E strobe high while sequencer reports idle");

    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> m_tvalid)
        else $error("processed transfer produced no result");

    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");

endmodule

`default_nettype wire
